/* src/blk2s_pkg.sv */
package blk2s_pkg;

    // One input transfer: a message byte or an end-of-message marker.
    typedef struct packed {
        logic       kind;
        logic [7:0] data_byte;
    } t_in_item;

    // One output transfer: a single digest word.
    typedef struct packed {
        logic [31:0] digest_word;
        logic [2:0]  word_index;
        logic        last_word;
    } t_out_item;

    // Input kind codes.
    localparam logic C_KIND_BYTE = 1'b0;
    localparam logic C_KIND_END  = 1'b1;

    // Initialization vector shared by chain reset and work vector setup.
    localparam logic [31:0] C_IV [8] = '{
        32'h6A09E667, 32'hBB67AE85, 32'h3C6EF372, 32'hA54FF53A,
        32'h510E527F, 32'h9B05688C, 32'h1F83D9AB, 32'h5BE0CD19
    };

    // Parameter block word: depth 1, fanout 1, no key, 32-byte digest.
    localparam logic [31:0] C_PARAM_WORD = 32'h01010020;

    localparam logic [6:0] C_BLOCK_BYTES = 7'd64;

    // Ten rounds of sixteen half-mix steps each.
    localparam logic [7:0] C_LAST_STEP = 8'd159;
    localparam logic [2:0] C_LAST_WORD = 3'd7;

    // Message word schedule, one row per round.
    localparam logic [3:0] C_SIGMA [10][16] = '{
        '{4'd0, 4'd1, 4'd2, 4'd3, 4'd4, 4'd5, 4'd6, 4'd7,
          4'd8, 4'd9, 4'd10, 4'd11, 4'd12, 4'd13, 4'd14, 4'd15},
        '{4'd14, 4'd10, 4'd4, 4'd8, 4'd9, 4'd15, 4'd13, 4'd6,
          4'd1, 4'd12, 4'd0, 4'd2, 4'd11, 4'd7, 4'd5, 4'd3},
        '{4'd11, 4'd8, 4'd12, 4'd0, 4'd5, 4'd2, 4'd15, 4'd13,
          4'd10, 4'd14, 4'd3, 4'd6, 4'd7, 4'd1, 4'd9, 4'd4},
        '{4'd7, 4'd9, 4'd3, 4'd1, 4'd13, 4'd12, 4'd11, 4'd14,
          4'd2, 4'd6, 4'd5, 4'd10, 4'd4, 4'd0, 4'd15, 4'd8},
        '{4'd9, 4'd0, 4'd5, 4'd7, 4'd2, 4'd4, 4'd10, 4'd15,
          4'd14, 4'd1, 4'd11, 4'd12, 4'd6, 4'd8, 4'd3, 4'd13},
        '{4'd2, 4'd12, 4'd6, 4'd10, 4'd0, 4'd11, 4'd8, 4'd3,
          4'd4, 4'd13, 4'd7, 4'd5, 4'd15, 4'd14, 4'd1, 4'd9},
        '{4'd12, 4'd5, 4'd1, 4'd15, 4'd14, 4'd13, 4'd4, 4'd10,
          4'd0, 4'd7, 4'd6, 4'd3, 4'd9, 4'd2, 4'd8, 4'd11},
        '{4'd13, 4'd11, 4'd7, 4'd14, 4'd12, 4'd1, 4'd3, 4'd9,
          4'd5, 4'd0, 4'd15, 4'd4, 4'd8, 4'd6, 4'd2, 4'd10},
        '{4'd6, 4'd15, 4'd14, 4'd9, 4'd11, 4'd3, 4'd0, 4'd8,
          4'd12, 4'd2, 4'd13, 4'd7, 4'd1, 4'd4, 4'd10, 4'd5},
        '{4'd10, 4'd2, 4'd8, 4'd4, 4'd7, 4'd6, 4'd1, 4'd5,
          4'd15, 4'd11, 4'd9, 4'd14, 4'd3, 4'd12, 4'd13, 4'd0}
    };

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic       latch;
        logic       wr_byte;
        logic       add_cnt;
        logic       load_v;
        logic       rd_en;
        logic [7:0] step;
        logic       fold;
        logic       wr_pend;
        logic       clear;
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic full;
    } t_dp_stat;

endpackage

/* src/blk2s_dp.sv */
module blk2s_dp import blk2s_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_dp_cmd     i_cmd,
    input  t_in_item    i_in_item,
    input  logic [2:0]  i_word_idx,
    output t_dp_stat    o_stat,
    output logic [31:0] o_digest_word
);

    // Block buffer: sixteen little-endian message words.
    logic [31:0] r_mem [16];
    logic [31:0] r_mdata;
    logic [3:0]  r_maddr;
    logic [3:0]  r_mpos;
    logic        r_g_en;

    // Work vector as four rows of four words; mixing always acts on column 0.
    logic [31:0] r_v [4][4];
    logic [31:0] n_v [4][4];
    logic [31:0] r_chain [8];
    logic [63:0] r_count;
    logic [6:0]  r_fill;
    logic [7:0]  r_pend;
    logic        r_final;

    logic [3:0]  w_rd_addr;
    logic [31:0] w_m;
    logic [31:0] w_a;
    logic [31:0] w_b;
    logic [31:0] w_c;
    logic [31:0] w_d;
    logic [31:0] w_a1;
    logic [31:0] w_d1;
    logic [31:0] w_c1;
    logic [31:0] w_b1;
    logic [31:0] w_dx;
    logic [31:0] w_bx;
    logic [31:0] w_tmp [4][4];
    logic [1:0]  w_shift [4];

    assign o_stat.full   = (r_fill == C_BLOCK_BYTES);
    assign o_digest_word = r_chain[i_word_idx];
    assign w_rd_addr     = C_SIGMA[i_cmd.step[7:4]][i_cmd.step[3:0]];

    // Buffer writes and the registered message word read.
    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_byte) begin
            r_mem[r_fill[5:2]][{r_fill[1:0], 3'b000} +: 8] <= i_in_item.data_byte;
        end else if (i_cmd.wr_pend) begin
            r_mem[0][7:0] <= r_pend;
        end
        if (i_cmd.rd_en) begin
            r_mdata <= r_mem[w_rd_addr];
            r_maddr <= w_rd_addr;
            r_mpos  <= i_cmd.step[3:0];
        end
        if (i_cmd.latch) begin
            r_pend  <= i_in_item.data_byte;
            r_final <= i_in_item.kind;
        end
    end

    // Bytes at or beyond the fill level read as zero padding.
    always_comb begin
        for (int k = 0; k < 4; k++) begin
            w_m[8*k +: 8] = ({1'b0, r_maddr, 2'(k)} < r_fill) ? r_mdata[8*k +: 8] : 8'h00;
        end
    end

    // Half of the mixing function; the second half uses the short rotations.
    assign w_a  = r_v[0][0];
    assign w_b  = r_v[1][0];
    assign w_c  = r_v[2][0];
    assign w_d  = r_v[3][0];
    assign w_a1 = w_a + w_b + w_m;
    assign w_dx = w_d ^ w_a1;
    assign w_d1 = r_mpos[0] ? {w_dx[7:0], w_dx[31:8]} : {w_dx[15:0], w_dx[31:16]};
    assign w_c1 = w_c + w_d1;
    assign w_bx = w_b ^ w_c1;
    assign w_b1 = r_mpos[0] ? {w_bx[6:0], w_bx[31:7]} : {w_bx[11:0], w_bx[31:12]};

    // After a full mix the rows rotate to bring the next column or diagonal to column 0.
    always_comb begin
        for (int r = 0; r < 4; r++) begin
            for (int c = 0; c < 4; c++) begin
                w_tmp[r][c] = r_v[r][c];
            end
            if (!r_mpos[0]) begin
                w_shift[r] = 2'd0;
            end else if (r_mpos[3:1] == 3'd3) begin
                w_shift[r] = 2'(1 + r);
            end else if (r_mpos[3:1] == 3'd7) begin
                w_shift[r] = 2'(5 - r);
            end else begin
                w_shift[r] = 2'd1;
            end
        end
        w_tmp[0][0] = w_a1;
        w_tmp[1][0] = w_b1;
        w_tmp[2][0] = w_c1;
        w_tmp[3][0] = w_d1;
        for (int r = 0; r < 4; r++) begin
            for (int c = 0; c < 4; c++) begin
                n_v[r][c] = w_tmp[r][2'(c + 32'(w_shift[r]))];
            end
        end
    end

    // Work vector setup and mixing.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_v) begin
            for (int c = 0; c < 4; c++) begin
                r_v[0][c] <= r_chain[c];
                r_v[1][c] <= r_chain[c + 4];
                r_v[2][c] <= C_IV[c];
            end
            r_v[3][0] <= C_IV[4] ^ r_count[31:0];
            r_v[3][1] <= C_IV[5] ^ r_count[63:32];
            r_v[3][2] <= C_IV[6] ^ {32{r_final}};
            r_v[3][3] <= C_IV[7];
        end else if (r_g_en) begin
            r_v <= n_v;
        end
    end

    // Chain words, byte counter, fill level and mix pipeline flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.clear) begin
            for (int i = 0; i < 8; i++) begin
                r_chain[i] <= (i == 0) ? (C_IV[0] ^ C_PARAM_WORD) : C_IV[i];
            end
            r_count <= '0;
            r_fill  <= '0;
            r_g_en  <= 1'b0;
        end else begin
            r_g_en <= i_cmd.rd_en;
            if (i_cmd.add_cnt) begin
                r_count <= r_count + 64'(r_fill);
            end
            if (i_cmd.fold) begin
                for (int i = 0; i < 4; i++) begin
                    r_chain[i]     <= r_chain[i] ^ r_v[0][i] ^ r_v[2][i];
                    r_chain[i + 4] <= r_chain[i + 4] ^ r_v[1][i] ^ r_v[3][i];
                end
            end
            if (i_cmd.wr_byte) begin
                r_fill <= r_fill + 7'd1;
            end else if (i_cmd.wr_pend) begin
                r_fill <= 7'd1;
            end
        end
    end

endmodule

/* src/blk2s_ctrl.sv */
module blk2s_ctrl import blk2s_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  t_in_item   i_in_item,
    input  logic       i_out_stall,
    input  t_dp_stat   i_stat,
    output logic       o_in_stall,
    output logic       o_out_valid,
    output logic [2:0] o_word_idx,
    output t_dp_cmd    o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_INIT,
        S_RUN,
        S_DRAIN,
        S_FOLD,
        S_EMIT
    } t_state;

    t_state     r_state;
    logic [7:0] r_step;
    logic [2:0] r_idx;
    logic       r_final;
    logic       r_out_valid;
    logic       w_accept;
    logic       w_compress;

    assign w_accept    = i_in_valid && (r_state == S_IDLE);
    assign w_compress  = (i_in_item.kind == C_KIND_END) || i_stat.full;
    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_word_idx  = r_idx;

    // Datapath commands decoded from the state.
    always_comb begin
        o_cmd.latch   = w_accept;
        o_cmd.wr_byte = w_accept && !w_compress;
        o_cmd.add_cnt = w_accept && w_compress;
        o_cmd.load_v  = (r_state == S_INIT);
        o_cmd.rd_en   = (r_state == S_RUN);
        o_cmd.step    = r_step;
        o_cmd.fold    = (r_state == S_FOLD);
        o_cmd.wr_pend = (r_state == S_FOLD) && !r_final;
        o_cmd.clear   = (r_state == S_EMIT) && !i_out_stall && (r_idx == C_LAST_WORD);
    end

    // Sequencer state and registered outputs.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_step      <= '0;
            r_idx       <= '0;
            r_final     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (w_accept && w_compress) begin
                        r_final <= i_in_item.kind;
                        r_state <= S_INIT;
                    end
                end
                S_INIT: begin
                    r_step  <= '0;
                    r_state <= S_RUN;
                end
                S_RUN: begin
                    if (r_step == C_LAST_STEP) begin
                        r_state <= S_DRAIN;
                    end else begin
                        r_step <= r_step + 8'd1;
                    end
                end
                S_DRAIN: begin
                    r_state <= S_FOLD;
                end
                S_FOLD: begin
                    if (r_final) begin
                        r_idx       <= '0;
                        r_out_valid <= 1'b1;
                        r_state     <= S_EMIT;
                    end else begin
                        r_state <= S_IDLE;
                    end
                end
                S_EMIT: begin
                    if (!i_out_stall) begin
                        if (r_idx == C_LAST_WORD) begin
                            r_out_valid <= 1'b0;
                            r_state     <= S_IDLE;
                        end else begin
                            r_idx <= r_idx + 3'd1;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

/* src/blake2s_256_hash.sv */
// BLAKE2s-256 engine: a message byte that fits the buffer is stored in it directly.
// A byte arriving at a full buffer, or an end-of-message item, starts a
// compression: one half-mix unit runs 160 steps of 10 rounds.
// Digest words follow the final compression, one per output transfer.
// Reset (synchronous, active low) loads the initial chain, clears counters.
// The engine reinitializes itself after each digest.
module blake2s_256_hash import blk2s_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_item  i_in_item,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_item
);

    t_dp_cmd     w_cmd;
    t_dp_stat    w_stat;
    logic [2:0]  w_idx;
    logic [31:0] w_word;

    // Controller.
    blk2s_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_item   (i_in_item),
        .i_out_stall (i_out_stall),
        .i_stat      (w_stat),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .o_word_idx  (w_idx),
        .o_cmd       (w_cmd)
    );

    // Datapath.
    blk2s_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .i_in_item     (i_in_item),
        .i_word_idx    (w_idx),
        .o_stat        (w_stat),
        .o_digest_word (w_word)
    );

    // Output payload.
    assign o_out_item.digest_word = w_word;
    assign o_out_item.word_index  = w_idx;
    assign o_out_item.last_word   = (w_idx == C_LAST_WORD);

    // No input transfer while a digest is being delivered.
    a_no_in_while_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_in_stall)
        else $error("input accepted while digest pending");

    // End of message always starts a compression.
    a_end_compresses: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall && i_in_item.kind == C_KIND_END) |=> o_in_stall)
        else $error("end of message did not start compression");

    // The digest ends after the last word.
    a_last_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_stall && o_out_item.last_word) |=> !o_out_valid)
        else $error("output continued after last word");

endmodule
